// File: rtl/circular_list_deque_with_search_assert.svh
// assertion macros shared by the deque rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef CIRCULAR_LIST_DEQUE_WITH_SEARCH_ASSERT_SVH
`define CIRCULAR_LIST_DEQUE_WITH_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS

`define CLDQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("cldq assertion failed");

`define CLDQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cldq implication failed");

`else

`define CLDQ_ASSERT(lbl, prop)

`define CLDQ_ASSERT_IMPL(lbl, ante, cons)

`endif

`endif

// File: rtl/cldq_pkg.sv
// types, constants and ring helpers for the deque with search
// used by the channel interfaces, controller, datapath and top level
`default_nettype none

package cldq_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int SUM_W      = CNT_W + 1;
  localparam int FIELD_W    = 32;
  localparam int WIDE_W     = DATA_WIDTH + FIELD_W;
  localparam int ACT_W      = 3;
  localparam int STAT_W     = 2;
  localparam int POS_W      = 5;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_SEARCH     = 3'd4,
    ACT_DUMP       = 3'd5
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    RES_STATUS,
    RES_POP,
    RES_FOUND,
    RES_NOT_FOUND,
    RES_ENTRY
  } res_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic      push_front;
    logic      push_back;
    logic      pop_front;
    logic      pop_back;
    logic      scan_start;
    logic      scan_next;
    logic      ld_out;
    res_kind_t kind;
    status_t   code;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic match;
    logic at_end;
  } sts_t;

  // slot of the k-th entry counted from the front
  function automatic logic [IDX_W-1:0] ring_add(logic [IDX_W-1:0] front,
                                                logic [CNT_W-1:0] k);
    logic [SUM_W-1:0] s;
    s = SUM_W'(front) + SUM_W'(k);
    if (s >= SUM_W'(CAPACITY)) begin
      s = s - SUM_W'(CAPACITY);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] ring_dec(logic [IDX_W-1:0] front);
    logic [IDX_W-1:0] r;
    if (front == '0) begin
      r = IDX_W'(CAPACITY - 1);
    end else begin
      r = front - IDX_W'(1);
    end
    return r;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] fit_in(logic [FIELD_W-1:0] v);
    logic [WIDE_W-1:0] t;
    t = WIDE_W'(v);
    return t[DATA_WIDTH-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] fit_out(logic [DATA_WIDTH-1:0] d);
    logic [WIDE_W-1:0] t;
    t = WIDE_W'(d);
    return t[FIELD_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/cldq_if.sv
// request and result channel interfaces of the deque
// depends on cldq_pkg
`default_nettype none

interface cldq_in_if import cldq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [ACT_W-1:0]           action;
  logic signed [FIELD_W-1:0]  data_in;

  modport source (output valid, output action, output data_in, input ready);
  modport sink   (input valid, input action, input data_in, output ready);
endinterface

interface cldq_out_if import cldq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [STAT_W-1:0]          status;
  logic signed [FIELD_W-1:0]  value_out;
  logic [POS_W-1:0]           position;
  logic                       last;

  modport source (output valid, output status, output value_out, output position,
                  output last, input ready);
  modport sink   (input valid, input status, input value_out, input position,
                  input last, output ready);
endinterface

`default_nettype wire

// File: rtl/cldq_ctrl.sv
// request sequencer: decodes requests, steps pops and scans, owns result valid
// depends on cldq_pkg and the assertion macro header
`default_nettype none
`include "circular_list_deque_with_search_assert.svh"

module cldq_ctrl import cldq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [ACT_W-1:0] in_action,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  sts_t             sts,
  output cmd_t             cmd
);

  state_t  state_r, state_nxt;
  logic    dump_r, dump_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    out_free;
  logic    accept;
  action_t act;

  assign act       = action_t'(in_action);
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    dump_nxt  = dump_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          dump_nxt = (act == ACT_DUMP);
          case (act) inside
            ACT_POP_FRONT, ACT_POP_BACK: begin
              if (!sts.empty) state_nxt = ST_POP;
            end
            ACT_SEARCH, ACT_DUMP: begin
              if (!sts.empty) state_nxt = ST_SCAN;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_POP: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (dump_r) begin
          if (out_free && sts.at_end) state_nxt = ST_IDLE;
        end else if (out_free && (sts.match || sts.at_end)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd      = '0;
    cmd.kind = RES_STATUS;
    cmd.code = STAT_OK;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (act) inside
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
              cmd.ld_out = 1'b1;
              if (sts.full) begin
                cmd.code = STAT_FULL;
              end else begin
                cmd.push_front = (act == ACT_PUSH_FRONT);
                cmd.push_back  = (act == ACT_PUSH_BACK);
              end
            end
            ACT_POP_FRONT, ACT_POP_BACK: begin
              if (sts.empty) begin
                cmd.ld_out = 1'b1;
                cmd.code   = STAT_EMPTY;
              end else begin
                cmd.pop_front = (act == ACT_POP_FRONT);
                cmd.pop_back  = (act == ACT_POP_BACK);
              end
            end
            ACT_SEARCH, ACT_DUMP: begin
              if (sts.empty) begin
                cmd.ld_out = 1'b1;
                cmd.code   = STAT_EMPTY;
              end else begin
                cmd.scan_start = 1'b1;
              end
            end
            default: cmd.ld_out = 1'b0;
          endcase
        end
      end
      ST_POP: begin
        cmd.kind   = RES_POP;
        cmd.ld_out = out_free;
      end
      ST_SCAN: begin
        if (dump_r) begin
          cmd.kind      = RES_ENTRY;
          cmd.ld_out    = out_free;
          cmd.scan_next = out_free && !sts.at_end;
        end else if (sts.match) begin
          cmd.kind   = RES_FOUND;
          cmd.ld_out = out_free;
        end else if (sts.at_end) begin
          cmd.kind   = RES_NOT_FOUND;
          cmd.ld_out = out_free;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      default: cmd.ld_out = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.ld_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dump_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dump_r      <= dump_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `CLDQ_ASSERT_IMPL(a_ld_into_free, cmd.ld_out, !out_valid_r || out_ready)
  `CLDQ_ASSERT_IMPL(a_scan_has_entries, state_r == ST_SCAN, !sts.empty)

endmodule

`default_nettype wire

// File: rtl/cldq_dp.sv
// datapath: ring store, front and count, scan index, result register
// depends on cldq_pkg and the assertion macro header
`default_nettype none
`include "circular_list_deque_with_search_assert.svh"

module cldq_dp import cldq_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [FIELD_W-1:0]        in_data,
  input  cmd_t                      cmd,
  output sts_t                      sts,
  output logic [STAT_W-1:0]         out_status,
  output logic signed [FIELD_W-1:0] out_value,
  output logic [POS_W-1:0]          out_position,
  output logic                      out_last
);

  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic [DATA_WIDTH-1:0] key_r, key_nxt;
  logic [IDX_W-1:0]      front_r, front_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [CNT_W-1:0]      idx_plus;
  logic [IDX_W-1:0]      rd_addr, wr_addr;
  logic                  rd_en, wr_en;
  logic [STAT_W-1:0]     status_r, status_nxt;
  logic [FIELD_W-1:0]    value_r, value_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic                  last_r, last_nxt;

  assign idx_plus   = CNT_W'(idx_r) + CNT_W'(1);
  assign sts.empty  = (count_r == '0);
  assign sts.full   = (count_r == CNT_W'(CAPACITY));
  assign sts.match  = (rd_data_r == key_r);
  assign sts.at_end = (idx_plus == count_r);

  assign wr_en = cmd.push_front || cmd.push_back;
  assign rd_en = cmd.pop_front || cmd.pop_back || cmd.scan_start || cmd.scan_next;

  always_comb begin
    wr_addr   = ring_add(front_r, count_r);
    rd_addr   = front_r;
    front_nxt = front_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    key_nxt   = key_r;
    if (cmd.push_front) begin
      wr_addr   = ring_dec(front_r);
      front_nxt = ring_dec(front_r);
      count_nxt = count_r + CNT_W'(1);
    end
    if (cmd.push_back) begin
      count_nxt = count_r + CNT_W'(1);
    end
    if (cmd.pop_front) begin
      front_nxt = ring_add(front_r, CNT_W'(1));
      count_nxt = count_r - CNT_W'(1);
    end
    if (cmd.pop_back) begin
      rd_addr   = ring_add(front_r, count_r - CNT_W'(1));
      count_nxt = count_r - CNT_W'(1);
    end
    if (cmd.scan_start) begin
      idx_nxt = '0;
      key_nxt = fit_in(in_data);
    end
    if (cmd.scan_next) begin
      rd_addr = ring_add(front_r, idx_plus);
      idx_nxt = idx_plus[IDX_W-1:0];
    end
  end

  // result register
  always_comb begin
    status_nxt = STAT_OK;
    value_nxt  = '0;
    pos_nxt    = '0;
    last_nxt   = 1'b1;
    case (cmd.kind)
      RES_STATUS:    status_nxt = cmd.code;
      RES_POP:       value_nxt  = fit_out(rd_data_r);
      RES_FOUND:     pos_nxt    = POS_W'(idx_plus);
      RES_NOT_FOUND: status_nxt = STAT_NOT_FOUND;
      RES_ENTRY: begin
        value_nxt = fit_out(rd_data_r);
        pos_nxt   = POS_W'(idx_plus);
        last_nxt  = sts.at_end;
      end
      default:       status_nxt = STAT_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= fit_in(in_data);
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    key_r <= key_nxt;
    if (cmd.ld_out) begin
      status_r <= status_nxt;
      value_r  <= value_nxt;
      pos_r    <= pos_nxt;
      last_r   <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  assign out_status   = status_r;
  assign out_value    = value_r;
  assign out_position = pos_r;
  assign out_last     = last_r;

  `CLDQ_ASSERT(a_count_in_range, count_r <= CNT_W'(CAPACITY))
  `CLDQ_ASSERT_IMPL(a_push_has_room, cmd.push_front || cmd.push_back, !sts.full)

endmodule

`default_nettype wire

// File: rtl/circular_list_deque_with_search.sv
// top level of the bounded deque with search and dump
// depends on cldq_pkg, cldq_if, cldq_ctrl and cldq_dp
`default_nettype none

// Bounded double-ended list of CAPACITY entries kept in a ring store.
// Each request on in_chan (push front/back, pop front/back, search, dump)
// is handled to completion before the next is taken; codes 6 and 7 are
// dropped without a result. Pushes, and any pop, search or dump on an
// empty list, give their single result in the cycle after acceptance.
// A pop is answered after the registered read of the ring store. Search
// reads one entry per cycle and stops at the first match or at the last
// entry; dump gives one result per cycle, count results marked with last
// on the final one, and pauses whenever out_chan is not ready.
// The result register lets a new request be taken in the cycle its
// predecessor's final result is consumed. The store is not cleared at
// reset; only entries that were pushed are ever read.
module circular_list_deque_with_search import cldq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  cldq_in_if.sink   in_chan,
  cldq_out_if.source out_chan
);

  cmd_t cmd;
  sts_t sts;

  cldq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_action (in_chan.action),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cldq_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_data      (in_chan.data_in),
    .cmd          (cmd),
    .sts          (sts),
    .out_status   (out_chan.status),
    .out_value    (out_chan.value_out),
    .out_position (out_chan.position),
    .out_last     (out_chan.last)
  );

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for circular_list_deque_with_search
// keeps a shadow ring of the list, predicts every result and checks them in order
// depends on cldq_pkg, cldq_if and the deque rtl
module testbench;
  import cldq_pkg::*;

  localparam int HALF_PERIOD    = 2;
  localparam int RESET_CYCLES   = 8;
  localparam int MAX_IDLE       = 13;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_PHASES  = 5;
  localparam int RANDOM_ROUNDS  = 45;
  localparam int PRESSURE_ITEMS = 16;
  localparam int MAX_PRINTED    = 40;

  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

  localparam logic [FIELD_W-1:0] CORNERS [8] = '{
    32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
    32'h0000_0001, 32'h5555_5555, 32'haaaa_aaaa, 32'hfffe_0001
  };
  localparam logic [FIELD_W-1:0] TAIL_KEY    = 32'h1234_5678;
  localparam logic [FIELD_W-1:0] MISSING_KEY = 32'h0bad_cafe;

  typedef struct packed {
    status_t            status;
    logic [FIELD_W-1:0] value;
    logic [POS_W-1:0]   position;
    logic               last;
  } result_t;

  logic clk = 1'b0;
  logic rst_n;

  cldq_in_if  req_if ();
  cldq_out_if res_if ();

  circular_list_deque_with_search u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if),
    .out_chan (res_if)
  );

  logic [DATA_WIDTH-1:0] ring_mem [CAPACITY];
  int      ring_front = 0;
  int      ring_count = 0;
  result_t due_results [$];
  int      error_count = 0;
  int      quiet_cycles = 0;
  bit      sender_idles = 1'b1;
  bit      receiver_idles = 1'b1;
  bit      hold_requested = 1'b0;

  always #(HALF_PERIOD) clk = ~clk;

  task automatic report_mismatch(string what, logic [FIELD_W-1:0] got,
                                 logic [FIELD_W-1:0] want);
    if (error_count < MAX_PRINTED) begin
      $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $time);
    end
    error_count++;
  endtask

  function automatic void queue_result(status_t st, logic [FIELD_W-1:0] v, int pos,
                                       bit lst);
    result_t r;
    r.status   = st;
    r.value    = v;
    r.position = POS_W'(pos);
    r.last     = lst;
    due_results.push_back(r);
  endfunction

  // shadow of the list: applies one accepted request and queues its results
  function automatic void apply_request(logic [ACT_W-1:0] act, logic [FIELD_W-1:0] data);
    logic [DATA_WIDTH-1:0] key;
    int slot;
    int k;
    int hit;
    key = data[DATA_WIDTH-1:0];
    hit = 0;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (ring_count == CAPACITY) begin
          queue_result(STAT_FULL, '0, 0, 1'b1);
        end else begin
          if (act == ACT_PUSH_FRONT) begin
            ring_front = (ring_front + CAPACITY - 1) % CAPACITY;
            slot = ring_front;
          end else begin
            slot = (ring_front + ring_count) % CAPACITY;
          end
          ring_mem[slot] = key;
          ring_count++;
          queue_result(STAT_OK, '0, 0, 1'b1);
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (ring_count == 0) begin
          queue_result(STAT_EMPTY, '0, 0, 1'b1);
        end else begin
          if (act == ACT_POP_FRONT) begin
            slot = ring_front;
            ring_front = (ring_front + 1) % CAPACITY;
          end else begin
            slot = (ring_front + ring_count - 1) % CAPACITY;
          end
          ring_count--;
          queue_result(STAT_OK, FIELD_W'(ring_mem[slot]), 0, 1'b1);
        end
      end
      ACT_SEARCH: begin
        if (ring_count == 0) begin
          queue_result(STAT_EMPTY, '0, 0, 1'b1);
        end else begin
          for (k = 0; k < ring_count && hit == 0; k++) begin
            if (ring_mem[(ring_front + k) % CAPACITY] == key) begin
              hit = k + 1;
            end
          end
          queue_result((hit != 0) ? STAT_OK : STAT_NOT_FOUND, '0, hit, 1'b1);
        end
      end
      ACT_DUMP: begin
        if (ring_count == 0) begin
          queue_result(STAT_EMPTY, '0, 0, 1'b1);
        end else begin
          for (k = 0; k < ring_count; k++) begin
            queue_result(STAT_OK, FIELD_W'(ring_mem[(ring_front + k) % CAPACITY]), k + 1,
                         k == ring_count - 1);
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [FIELD_W-1:0] random_value();
    case ($urandom_range(0, 3))
      0: return FIELD_W'($urandom_range(0, 7));
      1: return CORNERS[$urandom_range(0, 7)];
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(logic [ACT_W-1:0] act, logic [FIELD_W-1:0] data);
    int gap;
    gap = sender_idles ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.action  <= act;
    req_if.data_in <= data;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    apply_request(act, data);
  endtask

  task automatic test_empty_list();
    send_request(ACT_POP_FRONT, $urandom);
    send_request(ACT_POP_BACK, $urandom);
    send_request(ACT_SEARCH, CORNERS[0]);
    send_request(ACT_DUMP, $urandom);
    send_request(ACT_SPARE_LO, $urandom);
  endtask

  task automatic test_full_list();
    int k;
    for (k = 0; k < CAPACITY; k++) begin
      send_request((k % 2 == 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT,
                   (k == CAPACITY - 1) ? TAIL_KEY : CORNERS[k % 8]);
    end
    send_request(ACT_PUSH_FRONT, CORNERS[1]);
    send_request(ACT_PUSH_BACK, CORNERS[2]);
    // back entry must be found too
    send_request(ACT_SEARCH, TAIL_KEY);
    send_request(ACT_SEARCH, MISSING_KEY);
    send_request(ACT_DUMP, '0);
    send_request(ACT_POP_FRONT, '0);
    send_request(ACT_POP_BACK, '0);
  endtask

  task automatic test_random_traffic();
    int phase;
    int n;
    int pick;
    int push_w;
    int pop_w;
    logic [FIELD_W-1:0] data;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      push_w = (phase % 2 == 0) ? 55 : 20;
      pop_w  = (phase % 2 == 0) ? 20 : 55;
      sender_idles   = (phase != 1) && (phase != 3);
      receiver_idles = (phase != 1) && (phase != 2);
      for (n = 0; n < RANDOM_ROUNDS; n++) begin
        pick = $urandom_range(0, 99);
        data = random_value();
        if (pick < push_w) begin
          send_request($urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, data);
        end else if (pick < push_w + pop_w) begin
          send_request($urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT, data);
        end else if (pick < 90) begin
          if (ring_count > 0 && $urandom_range(0, 1)) begin
            data = FIELD_W'(ring_mem[(ring_front + $urandom_range(0, ring_count - 1))
                                     % CAPACITY]);
          end
          send_request(ACT_SEARCH, data);
        end else if (pick < 97) begin
          send_request(ACT_DUMP, data);
        end else begin
          send_request($urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO, data);
        end
      end
    end
  endtask

  task automatic test_backpressure();
    int n;
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    hold_requested = 1'b1;
    for (n = 0; n < PRESSURE_ITEMS; n++) begin
      send_request((n % 4 == 3) ? ACT_DUMP : ACT_PUSH_BACK, random_value());
    end
    receiver_idles = 1'b1;
  endtask

  // result side: random stalls, plus one long hold-off when asked
  initial begin
    int stall;
    res_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_requested) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_requested = 1'b0;
      end else begin
        stall = receiver_idles ? $urandom_range(0, MAX_IDLE) : 0;
        if (stall > 0) begin
          res_if.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      res_if.ready <= 1'b1;
      @(posedge clk);
      while (!res_if.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected result", res_if.value_out, '0);
      end else begin
        want = due_results.pop_front();
        if (res_if.status !== want.status) begin
          report_mismatch("status", FIELD_W'(res_if.status), FIELD_W'(want.status));
        end
        if (res_if.value_out !== want.value) begin
          report_mismatch("value_out", res_if.value_out, want.value);
        end
        if (res_if.position !== want.position) begin
          report_mismatch("position", FIELD_W'(res_if.position), FIELD_W'(want.position));
        end
        if (res_if.last !== want.last) begin
          report_mismatch("last", FIELD_W'(res_if.last), FIELD_W'(want.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    rst_n          <= 1'b0;
    req_if.valid   <= 1'b0;
    req_if.action  <= ACT_PUSH_FRONT;
    req_if.data_in <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_full_list();
    test_random_traffic();
    test_backpressure();
    req_if.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: circular_list_deque_with_search.f
+incdir+rtl
rtl/cldq_pkg.sv
rtl/cldq_if.sv
rtl/cldq_ctrl.sv
rtl/cldq_dp.sv
rtl/circular_list_deque_with_search.sv
verif/testbench.sv
